// File: hw/rtl/source_token_scanner_unit_macros.svh
// assertion macros for the token scanner
`ifndef SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define STS_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define STS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define STS_ASSERT_IMPL(label, clk, rst_n, prop)
`define STS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hw/rtl/sts_pkg.sv
// shared types, codes and keyword tables of the token scanner
package sts_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int OFFSET_BITS = 32;

	typedef enum logic [4:0] {
		M_IDLE, M_COMMENT, M_PLUS, M_MINUS, M_SLASH, M_PERCENT, M_ASSIGN, M_BANG,
		M_LT, M_GT, M_STAR, M_STAR2, M_AMP, M_AMP2, M_PIPE, M_PIPE2, M_NUM,
		M_UNDER, M_IDENT, M_STR
	} mode_t;

	localparam logic [5:0] K_END = 6'd0, K_ASPLUS = 6'd1, K_PLUS = 6'd2, K_ASMINUS = 6'd3,
		K_MINUS = 6'd4, K_ASSTAR = 6'd5, K_ASDSTAR = 6'd6, K_DSTAR = 6'd7, K_STAR = 6'd8,
		K_ASSLASH = 6'd9, K_SLASH = 6'd10, K_ASPERCENT = 6'd11, K_PERCENT = 6'd12,
		K_SEMI = 6'd13, K_COLON = 6'd14, K_COMMA = 6'd15, K_LPAREN = 6'd16,
		K_RPAREN = 6'd17, K_LBRACE = 6'd18, K_RBRACE = 6'd19, K_EQ = 6'd20,
		K_ASSIGN = 6'd21, K_NEQ = 6'd22, K_BANG = 6'd23, K_LE = 6'd24, K_LT = 6'd25,
		K_GE = 6'd26, K_GT = 6'd27, K_ASDAMP = 6'd28, K_DAMP = 6'd29, K_ASDPIPE = 6'd30,
		K_DPIPE = 6'd31, K_INTLIT = 6'd32, K_STRLIT = 6'd33, K_UNDER = 6'd34,
		K_IDENT = 6'd35, K_KW0 = 6'd36;

	localparam logic [2:0] E_NONE = 3'd0, E_UNKNOWN = 3'd1, E_AMP = 3'd2, E_PIPE = 3'd3,
		E_STRING = 3'd4;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam logic [15:0] COL_MAX = 16'hFFFF;
	localparam logic [30:0] INT_MAX = 31'h7FFFFFFF;

	typedef struct packed {
		logic [5:0]             kind;
		logic [23:0]            line;
		logic [15:0]            column;
		logic [OFFSET_BITS-1:0] offset;
		logic [LENGTH_BITS-1:0] length;
		logic [30:0]            value;
		logic [2:0]             err;
	} token_t;

	// keyword text, 7 chars each, zero padded, alphabetical
	typedef logic [6:0][7:0] kw_text_t;
	localparam kw_text_t KW_TEXT [16] = '{
		{8'd0, 8'd0, 8'd0, "l", "o", "o", "b"},
		{8'd0, 8'd0, "t", "s", "n", "o", "c"},
		{8'd0, 8'd0, 8'd0, "e", "s", "l", "e"},
		{8'd0, 8'd0, "e", "s", "l", "a", "f"},
		{8'd0, 8'd0, 8'd0, 8'd0, "n", "u", "f"},
		{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "f", "i"},
		{8'd0, 8'd0, 8'd0, 8'd0, "t", "n", "i"},
		{8'd0, 8'd0, 8'd0, "p", "o", "o", "l"},
		{8'd0, 8'd0, "h", "c", "t", "a", "m"},
		{8'd0, 8'd0, 8'd0, "t", "x", "e", "n"},
		{8'd0, 8'd0, "t", "n", "i", "r", "p"},
		{8'd0, "n", "r", "u", "t", "e", "r"},
		{8'd0, 8'd0, 8'd0, "p", "o", "t", "s"},
		{8'd0, 8'd0, 8'd0, "e", "u", "r", "t"},
		{8'd0, 8'd0, 8'd0, 8'd0, "r", "a", "v"},
		{8'd0, 8'd0, 8'd0, "d", "i", "o", "v"}
	};

	// candidates whose character at pos equals c
	function automatic logic [15:0] filter_mask(input logic [15:0] mask,
			input logic [LENGTH_BITS-1:0] pos, input logic [7:0] c);
		logic [15:0] keep;
		keep = '0;
		for (int i = 0; i < 16; i++) begin
			if (pos < LENGTH_BITS'(7) && KW_TEXT[i][pos[2:0]] == c)
				keep[i] = 1'b1;
		end
		return mask & keep;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

endpackage

// File: hw/rtl/sts_core.sv
// scanner state and per-byte token logic, one byte per cycle while take is high
module sts_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         byte_in,
	input  logic               end_mark,
	output logic               tok0_valid,
	output logic               tok1_valid,
	output sts_pkg::token_t    tok0,
	output sts_pkg::token_t    tok1
);

	localparam int LB = sts_pkg::LENGTH_BITS;
	localparam int OB = sts_pkg::OFFSET_BITS;
	localparam logic [LB-1:0] LEN_MAX = '1;

	sts_pkg::mode_t       mode_q, mode_d;
	logic [15:0]          cand_q, cand_d;
	logic [LB-1:0]        len_q, len_d;
	logic [OB-1:0]        toff_q, toff_d, pos_q;
	logic [23:0]          line_q, tline_q, tline_d;
	logic [15:0]          col_q, tcol_q, tcol_d;
	logic [30:0]          acc_q, acc_d;
	logic                 halted_q, halt_d;

	logic                 used, flushed_err, pend;
	logic [LB-1:0]        len_inc;
	logic [34:0]          acc_mul;
	logic [15:0]          fin_mask;
	logic [5:0]           kw_kind;
	sts_pkg::token_t      ft, st;
	logic                 fv, sv, serr, do_start;

	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + LB'(1);
	assign acc_mul = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(byte_in - 8'd48);
	assign fin_mask = sts_pkg::filter_mask(cand_q, len_q, 8'd0);

	always_comb begin
		kw_kind = sts_pkg::K_IDENT;
		for (int i = 15; i >= 0; i--)
			if (fin_mask[i]) kw_kind = sts_pkg::K_KW0 + 6'(i);
	end

	// token from the pending state as it stands
	always_comb begin
		ft = '{kind: sts_pkg::K_END, line: tline_q, column: tcol_q, offset: toff_q,
			length: LB'(1), value: '0, err: sts_pkg::E_NONE};
		fv = 1'b1;
		flushed_err = 1'b0;
		case (mode_q)
			sts_pkg::M_PLUS:    ft.kind = sts_pkg::K_PLUS;
			sts_pkg::M_MINUS:   ft.kind = sts_pkg::K_MINUS;
			sts_pkg::M_SLASH:   ft.kind = sts_pkg::K_SLASH;
			sts_pkg::M_PERCENT: ft.kind = sts_pkg::K_PERCENT;
			sts_pkg::M_ASSIGN:  ft.kind = sts_pkg::K_ASSIGN;
			sts_pkg::M_BANG:    ft.kind = sts_pkg::K_BANG;
			sts_pkg::M_LT:      ft.kind = sts_pkg::K_LT;
			sts_pkg::M_GT:      ft.kind = sts_pkg::K_GT;
			sts_pkg::M_STAR:    ft.kind = sts_pkg::K_STAR;
			sts_pkg::M_STAR2: begin
				ft.kind = sts_pkg::K_DSTAR;
				ft.length = LB'(2);
			end
			sts_pkg::M_AMP: begin
				ft.err = sts_pkg::E_AMP;
				flushed_err = 1'b1;
			end
			sts_pkg::M_AMP2: begin
				ft.kind = sts_pkg::K_DAMP;
				ft.length = LB'(2);
			end
			sts_pkg::M_PIPE: begin
				ft.err = sts_pkg::E_PIPE;
				flushed_err = 1'b1;
			end
			sts_pkg::M_PIPE2: begin
				ft.kind = sts_pkg::K_DPIPE;
				ft.length = LB'(2);
			end
			sts_pkg::M_NUM: begin
				ft.kind = sts_pkg::K_INTLIT;
				ft.length = len_q;
				ft.value = acc_q;
			end
			sts_pkg::M_UNDER:   ft.kind = sts_pkg::K_UNDER;
			sts_pkg::M_IDENT: begin
				ft.kind = kw_kind;
				ft.length = len_q;
			end
			sts_pkg::M_STR: begin
				ft.err = sts_pkg::E_STRING;
				ft.length = len_q;
				flushed_err = 1'b1;
			end
			default: fv = 1'b0;
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		cand_d = cand_q;
		len_d = len_q;
		toff_d = toff_q;
		tline_d = tline_q;
		tcol_d = tcol_q;
		acc_d = acc_q;
		halt_d = 1'b0;
		used = 1'b1;
		pend = 1'b0;
		st = '{kind: sts_pkg::K_END, line: tline_q, column: tcol_q, offset: toff_q,
			length: LB'(2), value: '0, err: sts_pkg::E_NONE};
		sv = 1'b0;
		serr = 1'b0;
		do_start = 1'b0;
		tok0 = ft;
		tok0_valid = 1'b0;
		tok1 = ft;
		tok1_valid = 1'b0;

		if (end_mark) begin
			// finish pending token, then the end token unless the pending token is an error
			mode_d = sts_pkg::M_IDLE;
			tok0 = ft;
			tok0_valid = fv;
			if (fv && flushed_err) begin
				halt_d = 1'b1;
			end else begin
				tline_d = line_q;
				tcol_d = col_q;
				toff_d = pos_q;
				st = '{kind: sts_pkg::K_END, line: line_q, column: col_q, offset: pos_q,
					length: '0, value: '0, err: sts_pkg::E_NONE};
				if (fv) begin
					tok1 = st;
					tok1_valid = 1'b1;
				end else begin
					tok0 = st;
					tok0_valid = 1'b1;
				end
			end
		end else begin
			case (mode_q)
				sts_pkg::M_COMMENT: if (byte_in == 8'h0A) mode_d = sts_pkg::M_IDLE;
				sts_pkg::M_PLUS, sts_pkg::M_MINUS, sts_pkg::M_SLASH, sts_pkg::M_PERCENT,
				sts_pkg::M_ASSIGN, sts_pkg::M_BANG, sts_pkg::M_LT, sts_pkg::M_GT: begin
					if (byte_in == "=") begin
						case (mode_q)
							sts_pkg::M_PLUS:    st.kind = sts_pkg::K_ASPLUS;
							sts_pkg::M_MINUS:   st.kind = sts_pkg::K_ASMINUS;
							sts_pkg::M_SLASH:   st.kind = sts_pkg::K_ASSLASH;
							sts_pkg::M_PERCENT: st.kind = sts_pkg::K_ASPERCENT;
							sts_pkg::M_ASSIGN:  st.kind = sts_pkg::K_EQ;
							sts_pkg::M_BANG:    st.kind = sts_pkg::K_NEQ;
							sts_pkg::M_LT:      st.kind = sts_pkg::K_LE;
							default:            st.kind = sts_pkg::K_GE;
						endcase
						pend = 1'b1;
						mode_d = sts_pkg::M_IDLE;
					end else used = 1'b0;
				end
				sts_pkg::M_STAR: begin
					if (byte_in == "=") begin
						st.kind = sts_pkg::K_ASSTAR;
						pend = 1'b1;
						mode_d = sts_pkg::M_IDLE;
					end else if (byte_in == "*") mode_d = sts_pkg::M_STAR2;
					else used = 1'b0;
				end
				sts_pkg::M_STAR2, sts_pkg::M_AMP2, sts_pkg::M_PIPE2: begin
					if (byte_in == "=") begin
						st.kind = (mode_q == sts_pkg::M_STAR2) ? sts_pkg::K_ASDSTAR :
							(mode_q == sts_pkg::M_AMP2) ? sts_pkg::K_ASDAMP : sts_pkg::K_ASDPIPE;
						st.length = LB'(3);
						pend = 1'b1;
						mode_d = sts_pkg::M_IDLE;
					end else used = 1'b0;
				end
				sts_pkg::M_AMP: if (byte_in == "&") mode_d = sts_pkg::M_AMP2; else used = 1'b0;
				sts_pkg::M_PIPE: if (byte_in == "|") mode_d = sts_pkg::M_PIPE2; else used = 1'b0;
				sts_pkg::M_NUM: begin
					if (sts_pkg::is_digit(byte_in)) begin
						acc_d = (acc_mul > 35'(sts_pkg::INT_MAX)) ? sts_pkg::INT_MAX : acc_mul[30:0];
						len_d = len_inc;
					end else used = 1'b0;
				end
				sts_pkg::M_UNDER, sts_pkg::M_IDENT: begin
					if (sts_pkg::is_alpha(byte_in) || sts_pkg::is_digit(byte_in) || byte_in == "_")
					begin
						cand_d = sts_pkg::filter_mask(cand_q, len_q, byte_in);
						len_d = len_inc;
						mode_d = sts_pkg::M_IDENT;
					end else used = 1'b0;
				end
				sts_pkg::M_STR: begin
					if (byte_in == 8'h22) begin
						st.kind = sts_pkg::K_STRLIT;
						st.length = len_q;
						pend = 1'b1;
						mode_d = sts_pkg::M_IDLE;
					end else if (byte_in == 8'h0A) used = 1'b0;
					else len_d = len_inc;
				end
				sts_pkg::M_IDLE: used = 1'b0;
				default: begin
					mode_d = sts_pkg::M_IDLE;
					used = 1'b0;
				end
			endcase

			if (pend) begin
				tok0 = st;
				tok0_valid = 1'b1;
			end

			if (!used) begin
				mode_d = sts_pkg::M_IDLE;
				tok0 = ft;
				tok0_valid = fv;
				if (fv && flushed_err) halt_d = 1'b1;
				do_start = !(fv && flushed_err) && mode_q != sts_pkg::M_STR
					&& mode_q != sts_pkg::M_AMP && mode_q != sts_pkg::M_PIPE;
			end

			if (do_start) begin
				st = '{kind: sts_pkg::K_END, line: line_q, column: col_q, offset: pos_q,
					length: LB'(1), value: '0, err: sts_pkg::E_NONE};
				if (byte_in == " " || byte_in == 8'h09 || byte_in == 8'h0A ||
						byte_in == 8'h0D || byte_in == 8'h0C) begin
					mode_d = sts_pkg::M_IDLE;
				end else if (byte_in == "#") begin
					mode_d = sts_pkg::M_COMMENT;
				end else begin
					tline_d = line_q;
					tcol_d = col_q;
					toff_d = pos_q;
					len_d = LB'(1);
					case (byte_in)
						"+": mode_d = sts_pkg::M_PLUS;
						"-": mode_d = sts_pkg::M_MINUS;
						"/": mode_d = sts_pkg::M_SLASH;
						"%": mode_d = sts_pkg::M_PERCENT;
						"=": mode_d = sts_pkg::M_ASSIGN;
						"!": mode_d = sts_pkg::M_BANG;
						"<": mode_d = sts_pkg::M_LT;
						">": mode_d = sts_pkg::M_GT;
						"*": mode_d = sts_pkg::M_STAR;
						"&": mode_d = sts_pkg::M_AMP;
						"|": mode_d = sts_pkg::M_PIPE;
						";": begin st.kind = sts_pkg::K_SEMI; sv = 1'b1; end
						":": begin st.kind = sts_pkg::K_COLON; sv = 1'b1; end
						",": begin st.kind = sts_pkg::K_COMMA; sv = 1'b1; end
						"(": begin st.kind = sts_pkg::K_LPAREN; sv = 1'b1; end
						")": begin st.kind = sts_pkg::K_RPAREN; sv = 1'b1; end
						"{": begin st.kind = sts_pkg::K_LBRACE; sv = 1'b1; end
						"}": begin st.kind = sts_pkg::K_RBRACE; sv = 1'b1; end
						8'h22: begin
							mode_d = sts_pkg::M_STR;
							len_d = '0;
							toff_d = pos_q + OB'(1);
						end
						default: begin
							if (sts_pkg::is_digit(byte_in)) begin
								mode_d = sts_pkg::M_NUM;
								acc_d = 31'(byte_in - 8'd48);
							end else if (byte_in == "_") begin
								mode_d = sts_pkg::M_UNDER;
								cand_d = '0;
							end else if (sts_pkg::is_alpha(byte_in)) begin
								mode_d = sts_pkg::M_IDENT;
								cand_d = sts_pkg::filter_mask(16'hFFFF, '0, byte_in);
							end else begin
								st.err = sts_pkg::E_UNKNOWN;
								sv = 1'b1;
								serr = 1'b1;
							end
						end
					endcase
				end
				if (sv) begin
					if (serr) halt_d = 1'b1;
					if (fv) begin
						tok1 = st;
						tok1_valid = 1'b1;
					end else begin
						tok0 = st;
						tok0_valid = 1'b1;
					end
				end
			end
		end
		if (halted_q) begin
			tok0_valid = 1'b0;
			tok1_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sts_pkg::M_IDLE;
			cand_q <= '0;
			len_q <= '0;
			toff_q <= '0;
			pos_q <= '0;
			line_q <= 24'd1;
			col_q <= 16'd1;
			tline_q <= 24'd1;
			tcol_q <= 16'd1;
			acc_q <= '0;
			halted_q <= 1'b0;
		end else if (take && !halted_q) begin
			mode_q <= mode_d;
			cand_q <= cand_d;
			len_q <= len_d;
			toff_q <= toff_d;
			tline_q <= tline_d;
			tcol_q <= tcol_d;
			acc_q <= acc_d;
			halted_q <= halt_d;
			if (!end_mark) begin
				pos_q <= pos_q + OB'(1);
				if (byte_in == 8'h0A) begin
					if (line_q != sts_pkg::LINE_MAX) line_q <= line_q + 24'd1;
					col_q <= 16'd1;
				end else if (col_q != sts_pkg::COL_MAX) begin
					col_q <= col_q + 16'd1;
				end
			end
		end
	end

endmodule

// File: hw/rtl/sts_out_queue.sv
// four-entry result queue, holds the tokens of one byte while the sink stalls
module sts_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push0,
	input  logic            push1,
	input  sts_pkg::token_t tok0,
	input  sts_pkg::token_t tok1,
	output logic            room,
	output logic            valid,
	input  logic            stall,
	output sts_pkg::token_t head,
	output logic            head_last
);

	`include "source_token_scanner_unit_macros.svh"

	sts_pkg::token_t ent_q [4];
	logic [3:0]      last_q;
	logic [1:0]      rd_q, wr_q;
	logic [2:0]      cnt_q;
	logic            pop;
	logic [2:0]      npush;

	assign valid = cnt_q != 3'd0;
	assign pop = valid && !stall;
	assign head = ent_q[rd_q];
	assign head_last = last_q[rd_q];
	// two free entries after this cycle's pop
	assign room = (cnt_q - {2'b00, pop}) <= 3'd2;
	assign npush = {2'b00, push0} + {2'b00, push1};

	always_ff @(posedge clk) begin
		if (push0) begin
			ent_q[wr_q] <= tok0;
			last_q[wr_q] <= !push1;
		end
		if (push1) begin
			ent_q[wr_q + 2'd1] <= tok1;
			last_q[wr_q + 2'd1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + npush[1:0];
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + npush - {2'b00, pop};
		end
	end

	`STS_ASSERT_IMPL(a_no_overflow, clk, arst_n, cnt_q <= 3'd4)
	`STS_ASSERT_NEXT(a_push1_needs_push0, clk, arst_n, push1, !$past(!push0))
	`STS_ASSERT_NEXT(a_pop_moves, clk, arst_n, pop && !push0, cnt_q == $past(cnt_q) - 3'd1)

endmodule

// File: hw/rtl/source_token_scanner_unit.sv
// token scanner top level: one source byte or end mark in, tokens out
// Takes one byte per cycle while the queue has room; the scanner state update is a
// single registered pass per byte. A byte yields zero, one or two tokens, which
// wait in a four-entry queue; input stall rises only when the queue lacks room
// for two more, so bytes that yield two tokens can stall input even with an open
// sink. After an error token the block swallows all input without result until reset.
module source_token_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        end_mark,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [23:0] start_line,
	output logic [15:0] start_column,
	output logic [31:0] start_offset,
	output logic [15:0] text_length,
	output logic [30:0] int_value,
	output logic [2:0]  error_code,
	output logic        last_of_run
);

	sts_pkg::token_t tok0, tok1, head;
	logic            v0, v1, room, take;

	assign in_stall = !room;
	assign take = in_valid && room;

	sts_core u_core (
		.clk(clk), .arst_n(arst_n), .take(take), .byte_in(byte_in), .end_mark(end_mark),
		.tok0_valid(v0), .tok1_valid(v1), .tok0(tok0), .tok1(tok1)
	);

	sts_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push0(take && v0), .push1(take && v1),
		.tok0(tok0), .tok1(tok1), .room(room), .valid(out_valid), .stall(out_stall),
		.head(head), .head_last(last_of_run)
	);

	assign token_kind = head.kind;
	assign start_line = head.line;
	assign start_column = head.column;
	assign start_offset = head.offset;
	assign text_length = head.length;
	assign int_value = head.value;
	assign error_code = head.err;

endmodule
